@@ hdl/fba_pkg.sv @@
package fba_pkg;

  localparam int unsigned SLOTS_DEFAULT = 8;
  localparam int unsigned FRAME_BYTES_W = 27;
  localparam logic [FRAME_BYTES_W-1:0] FRAME_BYTES_RESET = 27'd8294400;

  localparam logic FUNC_ACQUIRE = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic [2:0] ST_ACQUIRED  = 3'd0;
  localparam logic [2:0] ST_POOL_FULL = 3'd1;
  localparam logic [2:0] ST_TOO_LARGE = 3'd2;
  localparam logic [2:0] ST_FREED     = 3'd3;
  localparam logic [2:0] ST_IGNORED   = 3'd4;

  typedef struct packed {
    logic        func;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic [17:0] row_stride;
    logic [3:0]  pixel_format;
    logic [63:0] time_ns;
    logic [26:0] needed_bytes;
    logic [2:0]  release_slot;
  } fba_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] slot_index;
  } fba_rsp_t;

  typedef struct packed {
    logic load;
    logic exec;
  } fba_cmd_t;

  typedef enum logic [1:0] {
    FBA_IDLE,
    FBA_EXEC,
    FBA_RESP
  } fba_state_t;

endpackage

@@ hdl/fba_ctrl.sv @@
module fba_ctrl
  import fba_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  output logic     done,
  output fba_cmd_t cmd
);

  fba_state_t state;
  fba_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FBA_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      FBA_IDLE: begin
        if (start) begin
          state_next = FBA_EXEC;
        end
      end
      FBA_EXEC: begin
        state_next = FBA_RESP;
      end
      FBA_RESP: begin
        if (start) begin
          state_next = FBA_EXEC;
        end else begin
          state_next = FBA_IDLE;
        end
      end
      default: begin
        state_next = FBA_IDLE;
      end
    endcase
  end

  always_comb begin
    busy     = 1'b0;
    done     = 1'b0;
    cmd.load = 1'b0;
    cmd.exec = 1'b0;
    unique case (state)
      FBA_IDLE: begin
        cmd.load = start;
      end
      FBA_EXEC: begin
        busy     = 1'b1;
        cmd.exec = 1'b1;
      end
      FBA_RESP: begin
        done     = 1'b1;
        cmd.load = start;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

@@ hdl/fba_datapath.sv @@
module fba_datapath
  import fba_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
)
(
  input  logic                     clk,
  input  logic                     rst,
  input  fba_cmd_t                 cmd,
  input  fba_req_t                 req,
  input  logic                     cfg_valid,
  input  logic [FRAME_BYTES_W-1:0] cfg_data,
  output fba_rsp_t                 rsp
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [FRAME_BYTES_W-1:0] frame_bytes;
  logic                     req_func;
  logic [FRAME_BYTES_W-1:0] req_needed;
  logic [2:0]               req_release;
  logic [SLOTS-1:0]         busy_flags;
  logic [IDX_W-1:0]         search_start;
  fba_rsp_t                 rsp_next;

  logic [2*SLOTS-1:0] free_dbl;
  logic [2*SLOTS-1:0] free_rot;
  logic               found;
  logic [IDX_W-1:0]   offset;
  logic [IDX_W:0]     grant_sum;
  logic [IDX_W-1:0]   grant;
  logic [IDX_W+2:0]   grant_ext;
  logic [IDX_W+2:0]   rel_ext;
  logic [IDX_W-1:0]   rel_idx;
  logic               rel_in_pool;
  logic               fits;
  logic               do_grant;
  logic               do_free;

  always_comb begin
    free_dbl = {~busy_flags, ~busy_flags};
    free_rot = free_dbl >> search_start;
    found    = 1'b0;
    offset   = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (free_rot[k]) begin
        found  = 1'b1;
        offset = IDX_W'(k);
      end
    end
    grant_sum = {1'b0, search_start} + {1'b0, offset};
    if (grant_sum >= (IDX_W + 1)'(SLOTS)) begin
      grant_sum = grant_sum - (IDX_W + 1)'(SLOTS);
    end
    grant     = grant_sum[IDX_W-1:0];
    grant_ext = (IDX_W + 3)'(grant);

    rel_ext     = (IDX_W + 3)'(req_release);
    rel_idx     = rel_ext[IDX_W-1:0];
    rel_in_pool = rel_ext < (IDX_W + 3)'(SLOTS);

    fits     = req_needed <= frame_bytes;
    do_grant = (req_func == FUNC_ACQUIRE) && fits && found;
    do_free  = (req_func == FUNC_RELEASE) && rel_in_pool && busy_flags[rel_idx];

    rsp_next.status     = ST_ACQUIRED;
    rsp_next.slot_index = 3'd0;
    if (req_func == FUNC_ACQUIRE) begin
      if (!fits) begin
        rsp_next.status = ST_TOO_LARGE;
      end else if (!found) begin
        rsp_next.status = ST_POOL_FULL;
      end else begin
        rsp_next.status     = ST_ACQUIRED;
        rsp_next.slot_index = grant_ext[2:0];
      end
    end else begin
      rsp_next.slot_index = req_release;
      rsp_next.status     = do_free ? ST_FREED : ST_IGNORED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bytes  <= FRAME_BYTES_RESET;
      busy_flags   <= '0;
      search_start <= '0;
    end else begin
      if (cfg_valid) begin
        frame_bytes <= cfg_data;
      end
      if (cmd.exec) begin
        if (do_grant) begin
          busy_flags[grant] <= 1'b1;
          if (grant_sum + 1'b1 >= (IDX_W + 1)'(SLOTS)) begin
            search_start <= '0;
          end else begin
            search_start <= grant + 1'b1;
          end
        end
        if (do_free) begin
          busy_flags[rel_idx] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_func    <= req.func;
      req_needed  <= req.needed_bytes;
      req_release <= req.release_slot;
    end
    if (cmd.exec) begin
      rsp <= rsp_next;
    end
  end

endmodule

@@ hdl/frame_buffer_slot_allocator.sv @@
// Channel      Direction  Handshake             Payload
// request      in         start, busy           req (fba_req_t)
// result       out        done (one cycle)      rsp (fba_rsp_t)
// frame size   in         cfg_valid, cfg_ready  cfg_data (27 bits)
//
// Each request passes EXEC, which runs the rotating free-slot search over the
// busy flags and updates them, then RESP, with the result on rsp under done.
// A new transaction may be accepted in the cycle that presents a result.
// Synchronous reset frees every slot, clears the search pointer and loads the
// default frame size. The receiver cannot stall; cfg_ready is always high.
module frame_buffer_slot_allocator
  import fba_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
)
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  fba_req_t                 req,
  output logic                     done,
  output fba_rsp_t                 rsp,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [FRAME_BYTES_W-1:0] cfg_data
);

  fba_cmd_t cmd;

  assign cfg_ready = 1'b1;

  fba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  fba_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .rsp       (rsp)
  );

endmodule

@@ bench/tb_frame_buffer_slot_allocator.sv @@
`timescale 1ns / 100ps

module tb_frame_buffer_slot_allocator
  import fba_pkg::*;
();

  localparam int unsigned NSLOTS = SLOTS_DEFAULT;
  localparam int unsigned LIMIT_CYCLES = 300000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam logic [FRAME_BYTES_W-1:0] SIZE_MAX = 27'd67108864;
  localparam logic [FRAME_BYTES_W-1:0] NEED_ALL_ONES = '1;

  typedef enum logic [1:0] {
    STIM_REQ,
    STIM_DRAIN,
    STIM_CFG
  } stim_kind_t;

  typedef struct packed {
    stim_kind_t               kind;
    fba_req_t                 req;
    logic [FRAME_BYTES_W-1:0] size;
  } stim_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  fba_req_t                 req = '0;
  logic                     cfg_valid = 1'b0;
  logic [FRAME_BYTES_W-1:0] cfg_data = FRAME_BYTES_RESET;
  logic                     busy;
  logic                     done;
  fba_rsp_t                 rsp;
  logic                     cfg_ready;

  stim_t       stim_q[$];
  fba_rsp_t    pending_results[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  int unsigned quiet = 0;

  logic                     slot_taken [NSLOTS];
  logic [2:0]               search_from;
  logic [15:0]              held_width [NSLOTS];
  logic [15:0]              held_height [NSLOTS];
  logic [17:0]              held_stride [NSLOTS];
  logic [3:0]               held_format [NSLOTS];
  logic [63:0]              held_time [NSLOTS];
  logic [FRAME_BYTES_W-1:0] held_length [NSLOTS];
  logic [FRAME_BYTES_W-1:0] frame_size;

  frame_buffer_slot_allocator uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic fba_rsp_t grant_or_free(input fba_req_t r);
    fba_rsp_t o;
    int       s;
    logic     found;
    o = '0;
    found = 1'b0;
    if (r.func == FUNC_ACQUIRE) begin
      if (r.needed_bytes > frame_size) begin
        o.status = ST_TOO_LARGE;
      end else begin
        for (int k = 0; k < NSLOTS; k++) begin
          s = (int'(search_from) + k) % NSLOTS;
          if (!found && !slot_taken[s]) begin
            found = 1'b1;
            slot_taken[s] = 1'b1;
            held_width[s] = r.frame_width;
            held_height[s] = r.frame_height;
            held_stride[s] = r.row_stride;
            held_format[s] = r.pixel_format;
            held_time[s] = r.time_ns;
            held_length[s] = r.needed_bytes;
            search_from = 3'((s + 1) % NSLOTS);
            o.slot_index = 3'(s);
          end
        end
        o.status = found ? ST_ACQUIRED : ST_POOL_FULL;
      end
    end else begin
      s = r.release_slot;
      o.slot_index = r.release_slot;
      if (s < NSLOTS && slot_taken[s]) begin
        slot_taken[s] = 1'b0;
        held_width[s] = '0;
        held_height[s] = '0;
        held_stride[s] = '0;
        held_time[s] = '0;
        held_length[s] = frame_size;
        o.status = ST_FREED;
      end else begin
        o.status = ST_IGNORED;
      end
    end
    return o;
  endfunction

  function automatic int unsigned idle_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic fba_req_t acquire_req(input logic [FRAME_BYTES_W-1:0] need);
    fba_req_t r;
    r.func = FUNC_ACQUIRE;
    r.frame_width = 16'($urandom);
    r.frame_height = 16'($urandom);
    r.row_stride = 18'($urandom);
    r.pixel_format = 4'($urandom);
    r.time_ns = {$urandom, $urandom};
    r.needed_bytes = need;
    r.release_slot = 3'($urandom);
    return r;
  endfunction

  function automatic fba_req_t release_req(input logic [2:0] slot);
    fba_req_t r;
    r = acquire_req(27'($urandom));
    r.func = FUNC_RELEASE;
    r.release_slot = slot;
    return r;
  endfunction

  function automatic void queue_req(input fba_req_t r);
    stim_q.push_back('{STIM_REQ, r, '0});
  endfunction

  function automatic void queue_cfg(input logic [FRAME_BYTES_W-1:0] size);
    stim_q.push_back('{STIM_CFG, '0, size});
  endfunction

  always @(posedge clk) begin
    logic  drive_start;
    logic  drive_cfg;
    stim_t nxt;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      for (int i = 0; i < NSLOTS; i++) begin
        slot_taken[i] = 1'b0;
        held_width[i] = '0;
        held_height[i] = '0;
        held_stride[i] = '0;
        held_format[i] = '0;
        held_time[i] = '0;
        held_length[i] = FRAME_BYTES_RESET;
      end
      search_from = '0;
      frame_size = FRAME_BYTES_RESET;
      gap_left = 0;
      quiet = 0;
    end else begin
      drive_start = start;
      drive_cfg = cfg_valid;
      if (start && !busy) begin
        pending_results.push_back(grant_or_free(req));
        drive_start = 1'b0;
        gap_left = idle_gap();
      end
      if (cfg_valid && cfg_ready) begin
        frame_size = cfg_data;
        drive_cfg = 1'b0;
        gap_left = idle_gap();
      end
      quiet = (pending_results.size() == 0) ? quiet + 1 : 0;
      if (!drive_start && !drive_cfg && stim_q.size() != 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          nxt = stim_q[0];
          case (nxt.kind)
            STIM_REQ: begin
              void'(stim_q.pop_front());
              req <= nxt.req;
              drive_start = 1'b1;
            end
            STIM_DRAIN: begin
              if (pending_results.size() == 0) void'(stim_q.pop_front());
            end
            default: begin
              if (quiet >= SETTLE_CYCLES) begin
                void'(stim_q.pop_front());
                cfg_data <= nxt.size;
                drive_cfg = 1'b1;
              end
            end
          endcase
        end
      end
      start <= drive_start;
      cfg_valid <= drive_cfg;
    end
  end

  always @(posedge clk) begin
    fba_rsp_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with no transaction outstanding: status %0d slot_index %0d",
               rsp.status, rsp.slot_index);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp.status);
          fail_count++;
        end
        if (rsp.slot_index !== want.slot_index) begin
          $error("slot_index: expected %0d, actual %0d", want.slot_index, rsp.slot_index);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("** frame_buffer_slot_allocator: FAILED **");
      $finish;
    end
  end

  initial begin
    fba_req_t                 r;
    logic [FRAME_BYTES_W-1:0] fb;
    int unsigned              pick;

    r = '0;
    r.func = FUNC_ACQUIRE;
    queue_req(r);
    r = '1;
    r.func = FUNC_ACQUIRE;
    r.needed_bytes = FRAME_BYTES_RESET;
    queue_req(r);
    queue_req(acquire_req(FRAME_BYTES_RESET + 27'd1));
    queue_req(acquire_req(NEED_ALL_ONES));
    queue_req(release_req(3'd7));
    queue_req(release_req(3'd0));
    queue_req(release_req(3'd0));
    for (int i = 0; i < 8; i++) queue_req(acquire_req(27'($urandom_range(0, 4096))));
    queue_req(release_req(3'd4));
    queue_req(acquire_req(27'd100));
    stim_q.push_back('{STIM_DRAIN, '0, '0});
    queue_cfg(27'd1);
    queue_req(release_req(3'd5));
    queue_req(acquire_req(27'd1));
    queue_req(acquire_req(27'd2));

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: fb = 27'd1;
        1: fb = SIZE_MAX;
        2: fb = 27'($urandom_range(1, 4096));
        9: fb = FRAME_BYTES_RESET;
        default: fb = 27'($urandom_range(1, SIZE_MAX));
      endcase
      queue_cfg(fb);
      for (int i = 0; i < 103; i++) begin
        if (i == 50 && p % 3 == 0) stim_q.push_back('{STIM_DRAIN, '0, '0});
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          queue_req(release_req(3'($urandom)));
        end else if (pick < 55) begin
          queue_req(acquire_req(27'($urandom_range(fb + 1, NEED_ALL_ONES))));
        end else if (pick < 62) begin
          queue_req(acquire_req(pick[0] ? fb : '0));
        end else begin
          queue_req(acquire_req(27'($urandom_range(0, fb))));
        end
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    do @(negedge clk);
    while (stim_q.size() != 0 || pending_results.size() != 0 || start || cfg_valid);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("** frame_buffer_slot_allocator: PASSED **");
    end else begin
      $display("** frame_buffer_slot_allocator: FAILED **");
    end
    $finish;
  end

endmodule
